@@ rtl/core/ifdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifdc_pkg
// Shared types and codes of the directory offset duplicate checker.
// ----------------------------------------------------------------------------
package ifdc_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // item kinds
  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  // one stored table entry
  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] tag;
  } store_entry_t;

endpackage

@@ rtl/core/ifdc_entry_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifdc_entry_if
// Valid/ready channel carrying one raw directory entry or a clear item.
// ----------------------------------------------------------------------------
interface ifdc_entry_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        value_is_offset;
  logic [31:0] data_offset;
  logic [15:0] tag_number;

  modport source (output valid, kind, value_is_offset, data_offset, tag_number,
                  input ready);
  modport sink (input valid, kind, value_is_offset, data_offset, tag_number,
                output ready);
endinterface

@@ rtl/core/ifdc_report_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifdc_report_if
// Valid/ready channel carrying one check result.
// ----------------------------------------------------------------------------
interface ifdc_report_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] earlier_tag;

  modport source (output valid, status, earlier_tag, input ready);
  modport sink (input valid, status, earlier_tag, output ready);
endinterface

@@ rtl/core/ifdc_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifdc_store
// Offset/tag table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ifdc_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  ifdc_pkg::store_entry_t wr_data,
  input  logic [AW-1:0]         rd_addr,
  output ifdc_pkg::store_entry_t rd_data
);

  ifdc_pkg::store_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/ifd_offset_duplicate_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_offset_duplicate_checker
// Flags directory entries whose data offset was already used by an earlier
// entry of the same directory, walking the stored offsets with one comparator.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | width
//  entry   | in  | kind, value_is_offset, data_offset, tag_number   | 1,1,32,16
//  report  | out | status, earlier_tag                              | 2,16
//
//  An offset entry starts a scan in which the sequencer reads
//  one stored entry per cycle through the table's single read port and
//  compares it with the registered offset; the first match ends the scan.
//  Clear and inline items skip the scan and go from idle to the result state.
//  Synchronous reset empties the table (count to zero); no clearing pass.
//  A new item is taken while the previous result waits in the output
//  register; a stalled report only blocks once the next result is ready.
// ----------------------------------------------------------------------------
module ifd_offset_duplicate_checker #(
  parameter int MAX_OFFSETS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  ifdc_entry_if.sink           entry,
  ifdc_report_if.source        report
);

  localparam int AW = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
  localparam int CW = $clog2(MAX_OFFSETS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_OFFSETS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  state_t                 state;
  logic [CW-1:0]          stored_count;
  logic [CW-1:0]          idx;
  logic                   cmp_vld;
  logic [31:0]            key_offset;
  logic [15:0]            key_tag;
  ifdc_pkg::status_t      res_status;
  logic [15:0]            res_tag;

  ifdc_pkg::store_entry_t rd_data;
  ifdc_pkg::store_entry_t wr_data;
  logic                   hit;
  logic                   scan_end;
  logic                   wr_en;
  logic                   rd_issue;
  logic                   out_free;

  // comparator on the entry just read
  assign hit      = cmp_vld && (rd_data.offset == key_offset);
  assign scan_end = (state == S_SCAN) && !hit && (idx == stored_count);
  assign rd_issue = (state == S_SCAN) && !hit && (idx != stored_count);
  assign wr_en    = scan_end && (stored_count != FULL_COUNT);
  assign wr_data  = '{offset: key_offset, tag: key_tag};
  assign out_free = !report.valid || report.ready;

  assign entry.ready = (state == S_IDLE);

  ifdc_store #(
    .DEPTH (MAX_OFFSETS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (stored_count[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // sequencer, table count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      idx          <= '0;
      cmp_vld      <= 1'b0;
      report.valid <= 1'b0;
    end else begin
      // output register: load a waiting result or drop a taken one
      if (state == S_RESP && out_free) begin
        report.valid       <= 1'b1;
        report.status      <= res_status;
        report.earlier_tag <= res_tag;
      end else if (report.ready) begin
        report.valid <= 1'b0;
      end
      cmp_vld <= rd_issue;
      unique case (state)
        S_IDLE: begin
          if (entry.valid) begin
            key_offset <= entry.data_offset;
            key_tag    <= entry.tag_number;
            res_status <= ifdc_pkg::ST_OK;
            res_tag    <= '0;
            idx        <= '0;
            if (entry.kind == ifdc_pkg::KIND_CLEAR) begin
              stored_count <= '0;
              state        <= S_RESP;
            end else if (entry.value_is_offset) begin
              state <= S_SCAN;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            res_status <= ifdc_pkg::ST_DUP;
            res_tag    <= rd_data.tag;
            state      <= S_RESP;
          end else if (scan_end) begin
            if (stored_count == FULL_COUNT) begin
              res_status <= ifdc_pkg::ST_FULL;
            end else begin
              stored_count <= stored_count + CW'(1);
            end
            state <= S_RESP;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= FULL_COUNT)
    else $error("stored count above table depth");

  // no write into a full table
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> stored_count != FULL_COUNT)
    else $error("write into full table");

  // count moves by one on append, or drops to zero on clear
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (stored_count == $past(stored_count)) ||
                    (stored_count == $past(stored_count) + CW'(1)) ||
                    (stored_count == '0))
    else $error("stored count jumped");

  // compare data only pending while scanning
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> state == S_SCAN)
    else $error("compare pending outside scan");

  // a duplicate result carries a tag from the table path, a scan ends in resp
  a_hit_to_resp: assert property (@(posedge clk) disable iff (rst)
    hit |=> state == S_RESP && res_status == ifdc_pkg::ST_DUP)
    else $error("hit not reported as duplicate");

endmodule
